// ----- rtl/core/ps2mpt_pkg.sv -----
`default_nettype none

package ps2mpt_pkg;

   localparam int RX_BYTE_BITS = 8;
   localparam int CURSOR_BITS  = 16;
   // a delta with sign and overflow spans -511 .. 510
   localparam int DELTA_BITS   = 10;

   localparam logic signed [DELTA_BITS-1:0] OVERFLOW_STEP = 10'sd255;

   // bit positions in packet byte 0
   localparam int FLAG_LEFT   = 0;
   localparam int FLAG_RIGHT  = 1;
   localparam int FLAG_MIDDLE = 2;
   localparam int FLAG_SYNC   = 3;
   localparam int FLAG_X_SIGN = 4;
   localparam int FLAG_Y_SIGN = 5;
   localparam int FLAG_X_OVF  = 6;
   localparam int FLAG_Y_OVF  = 7;

   typedef struct packed {
      logic                   emit;
      logic [CURSOR_BITS-1:0] cursor_x;
      logic [CURSOR_BITS-1:0] cursor_y;
      logic                   left_pressed;
      logic                   right_pressed;
      logic                   middle_pressed;
   } tracker_result_type;

endpackage

`default_nettype wire

// ----- rtl/core/ps2mpt_if.sv -----
`default_nettype none

interface ps2mpt_req_if import ps2mpt_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic [RX_BYTE_BITS-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ps2mpt_rsp_if import ps2mpt_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [CURSOR_BITS-1:0] cursor_x;
   logic [CURSOR_BITS-1:0] cursor_y;
   logic                   left_pressed;
   logic                   right_pressed;
   logic                   middle_pressed;

   modport source (output valid, output cursor_x, output cursor_y, output left_pressed,
                   output right_pressed, output middle_pressed, input ready);
   modport sink   (input valid, input cursor_x, input cursor_y, input left_pressed,
                   input right_pressed, input middle_pressed, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ps2mpt_axis.sv -----
`default_nettype none

module ps2mpt_axis import ps2mpt_pkg::*; #(
   parameter int POSITION_BITS = 16
) (
   input  logic [POSITION_BITS-1:0] pos,
   input  logic [RX_BYTE_BITS-1:0]  delta_byte,
   input  logic                     negative,
   input  logic                     overflow,
   input  logic                     subtract,
   output logic [POSITION_BITS-1:0] pos_next
);

   logic signed [DELTA_BITS-1:0]      base_delta;
   logic signed [DELTA_BITS-1:0]      ovf_delta;
   logic signed [DELTA_BITS-1:0]      delta_sum;
   logic signed [DELTA_BITS-1:0]      eff_delta;
   logic signed [POSITION_BITS+1:0]   sum;

   always_comb begin
      // sign bit extends the byte, so a negative zero byte reads as -256
      base_delta = signed'({negative, negative, delta_byte});
      if (overflow) begin
         ovf_delta = negative ? -OVERFLOW_STEP : OVERFLOW_STEP;
      end else begin
         ovf_delta = '0;
      end
      delta_sum = base_delta + ovf_delta;
      eff_delta = subtract ? -delta_sum : delta_sum;
      sum = signed'({2'b00, pos}) + (POSITION_BITS+2)'(eff_delta);
      if (sum[POSITION_BITS+1]) begin
         pos_next = '0;
      end else if (sum[POSITION_BITS]) begin
         pos_next = '1;
      end else begin
         pos_next = sum[POSITION_BITS-1:0];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/ps2mpt_tracker.sv -----
`default_nettype none

module ps2mpt_tracker import ps2mpt_pkg::*; #(
   parameter int POSITION_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [RX_BYTE_BITS-1:0] rx_byte,
   output tracker_result_type      result
);

   typedef enum logic [1:0] {
      PH_FLAGS,
      PH_XDELTA,
      PH_YDELTA
   } phase_type;

   logic                     skip_first_ff, skip_first_in;
   phase_type                phase_ff, phase_in;
   logic [RX_BYTE_BITS-1:0]  flags_byte_ff, flags_byte_in;
   logic [RX_BYTE_BITS-1:0]  x_delta_byte_ff, x_delta_byte_in;
   logic [POSITION_BITS-1:0] pos_x_ff, pos_x_in;
   logic [POSITION_BITS-1:0] pos_y_ff, pos_y_in;
   logic [POSITION_BITS-1:0] new_x, new_y;

   ps2mpt_axis #(.POSITION_BITS(POSITION_BITS)) u_axis_x (
      .pos        (pos_x_ff),
      .delta_byte (x_delta_byte_ff),
      .negative   (flags_byte_ff[FLAG_X_SIGN]),
      .overflow   (flags_byte_ff[FLAG_X_OVF]),
      .subtract   (1'b0),
      .pos_next   (new_x)
   );

   // screen y grows downward
   ps2mpt_axis #(.POSITION_BITS(POSITION_BITS)) u_axis_y (
      .pos        (pos_y_ff),
      .delta_byte (rx_byte),
      .negative   (flags_byte_ff[FLAG_Y_SIGN]),
      .overflow   (flags_byte_ff[FLAG_Y_OVF]),
      .subtract   (1'b1),
      .pos_next   (new_y)
   );

   always_comb begin
      skip_first_in   = skip_first_ff;
      phase_in        = phase_ff;
      flags_byte_in   = flags_byte_ff;
      x_delta_byte_in = x_delta_byte_ff;
      pos_x_in        = pos_x_ff;
      pos_y_in        = pos_y_ff;
      result.emit     = 1'b0;
      if (skip_first_ff) begin
         skip_first_in = 1'b0;
      end else begin
         unique case (phase_ff)
            PH_XDELTA: begin
               x_delta_byte_in = rx_byte;
               phase_in        = PH_YDELTA;
            end
            PH_YDELTA: begin
               pos_x_in    = new_x;
               pos_y_in    = new_y;
               phase_in    = PH_FLAGS;
               result.emit = 1'b1;
            end
            default: begin
               // bytes without the sync bit are dropped until alignment
               if (rx_byte[FLAG_SYNC]) begin
                  flags_byte_in = rx_byte;
                  phase_in      = PH_XDELTA;
               end else begin
                  phase_in = PH_FLAGS;
               end
            end
         endcase
      end
      result.cursor_x       = CURSOR_BITS'(new_x);
      result.cursor_y       = CURSOR_BITS'(new_y);
      result.left_pressed   = flags_byte_ff[FLAG_LEFT];
      result.right_pressed  = flags_byte_ff[FLAG_RIGHT];
      result.middle_pressed = flags_byte_ff[FLAG_MIDDLE];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_first_ff   <= 1'b1;
         phase_ff        <= PH_FLAGS;
         flags_byte_ff   <= '0;
         x_delta_byte_ff <= '0;
         pos_x_ff        <= '0;
         pos_y_ff        <= '0;
      end else if (step) begin
         skip_first_ff   <= skip_first_in;
         phase_ff        <= phase_in;
         flags_byte_ff   <= flags_byte_in;
         x_delta_byte_ff <= x_delta_byte_in;
         pos_x_ff        <= pos_x_in;
         pos_y_ff        <= pos_y_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/ps2mpt_packet_tracker_core.sv -----
// PS/2 mouse packet tracker.
// req_chan carries one received mouse byte per request; rsp_chan carries the
// cursor position and the three button states, one response for each
// complete 3-byte packet. Bytes that do not complete a packet give nothing.
// A byte goes into an input register at the edge it is accepted and is
// decoded from there into the response register once the tracker may step;
// a response comes from that register, not straight from the byte.
// One byte per cycle is accepted unless a packet-completing byte is held;
// the position update is a single add and clamp per axis in between.
// While a response waits on rsp_chan.ready, bytes that give no response
// still pass; a packet-completing byte holds in the input register and
// req_chan.ready drops once that register is occupied.
// Reset clears the cursor to 0,0, resets packet alignment and arms the drop
// of the first byte that arrives after it.
`default_nettype none

module ps2_mouse_packet_tracker_core import ps2mpt_pkg::*; #(
   parameter int POSITION_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   ps2mpt_req_if.sink          req_chan,
   ps2mpt_rsp_if.source        rsp_chan
);

   logic                    in_valid_ff;
   logic [RX_BYTE_BITS-1:0] in_byte_ff;
   logic                    rsp_valid_ff;
   tracker_result_type      rsp_payload_ff;
   tracker_result_type      result;
   logic                    out_free;
   logic                    step;
   logic                    req_take;

   ps2mpt_tracker #(.POSITION_BITS(POSITION_BITS)) u_tracker (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (in_byte_ff),
      .result  (result)
   );

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign step           = in_valid_ff && (!result.emit || out_free);
   assign req_chan.ready = !in_valid_ff || step;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (step) begin
            in_valid_ff <= 1'b0;
         end
         if (step && result.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_chan.rx_byte;
      end
      if (step && result.emit) begin
         rsp_payload_ff <= result;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.cursor_x       = rsp_payload_ff.cursor_x;
   assign rsp_chan.cursor_y       = rsp_payload_ff.cursor_y;
   assign rsp_chan.left_pressed   = rsp_payload_ff.left_pressed;
   assign rsp_chan.right_pressed  = rsp_payload_ff.right_pressed;
   assign rsp_chan.middle_pressed = rsp_payload_ff.middle_pressed;

   // a completed packet always shows up as a response next cycle
   a_emit_to_rsp: assert property (@(posedge clock) disable iff (reset)
      step && result.emit |=> rsp_valid_ff)
      else $error("completed packet did not raise response valid");

   // a stalled response is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |-> !(step && result.emit))
      else $error("response overwritten while stalled");

   // an occupied input register only takes a new byte when it drains
   a_no_input_drop: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step |-> !req_take)
      else $error("input byte accepted over a held byte");

endmodule

`default_nettype wire
